@@ rtl/scpc_pkg.sv @@
package scpc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CG_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CG_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MAX = 3'd5;

    // reset values
    localparam logic       RST_ENABLE   = 1'b1;
    localparam logic [7:0] RST_LUMA_MIN = 8'd60;
    localparam logic [7:0] RST_CG_MIN   = 8'd85;
    localparam logic [7:0] RST_CG_MAX   = 8'd135;
    localparam logic [8:0] RST_BAND_MIN = 9'd260;
    localparam logic [8:0] RST_BAND_MAX = 9'd280;

    // datapath widths
    localparam int CG_W   = 18;  // cg with 10 fraction bits
    localparam int BAND_W = 19;  // cr + cg with 10 fraction bits
    localparam int UV_W   = 16;  // offset chroma in hundredths
    localparam int P_W    = 29;  // rotation products
    localparam int X_W    = 30;  // rotated coordinates
    localparam int A_W    = 29;  // magnitudes
    localparam int R_W    = 20;  // rounded magnitudes
    localparam int SQ_W   = 2 * R_W;
    localparam int PX_W   = R_W + 21;
    localparam int PW_W   = R_W + 23;
    localparam int T_W    = 61;
    localparam int S_W    = 62;

    // cg = 131072 - 326 r + 450 g - 124 b
    localparam logic [CG_W-1:0] CG_BIAS = 18'd131072;
    localparam logic [CG_W-1:0] CG_KR   = 18'd326;
    localparam logic [CG_W-1:0] CG_KG   = 18'd450;
    localparam logic [CG_W-1:0] CG_KB   = 18'd124;

    localparam logic [UV_W-1:0]        CHROMA_SCALE = 16'd100;
    localparam logic signed [UV_W-1:0] CB_OFFSET    = 16'sd10938;
    localparam logic signed [UV_W-1:0] CR_OFFSET    = 16'sd15202;

    // q2.14 rotation
    localparam logic signed [UV_W-1:0] ROT_COS = -16'sd13414;
    localparam logic signed [UV_W-1:0] ROT_SIN = 16'sd9407;
    localparam int Q14_ONE = 16384;
    localparam logic signed [X_W-1:0] X_OFFSET = 30'sd2621440;  // 160 * 2^14
    localparam logic signed [X_W-1:0] W_OFFSET = 30'sd3948544;  // 241 * 2^14

    // ellipse axes in hundredths
    localparam int AXIS_A = 2539;
    localparam int AXIS_B = 1403;
    localparam logic [A_W-1:0] AX_LIM = A_W'(AXIS_A * Q14_ONE);
    localparam logic [A_W-1:0] AW_LIM = A_W'(AXIS_B * Q14_ONE);
    localparam logic [A_W:0]   ROUND_HALF = 30'd32;
    localparam int ROUND_SHIFT = 6;

    localparam logic [20:0] KX = 21'(AXIS_B * AXIS_B);
    localparam logic [22:0] KW = 23'(AXIS_A * AXIS_A);
    localparam logic [63:0] ELL_ROOT = 64'(AXIS_A) * 64'(AXIS_B) * 64'd256;
    localparam logic [S_W-1:0] ELL_LIM = S_W'(ELL_ROOT * ELL_ROOT);

    localparam int LATENCY = 8;

endpackage

@@ rtl/skin_color_pixel_classifier_unit.sv @@
// skin color pixel classifier
//
// input channel: an item (one pixel given as red, green, blue and as luma,
// chroma_red, chroma_blue) is taken at a rising edge with start high and
// busy low. busy stays low, so a pixel may be offered every cycle.
// result channel: o_valid is high for one cycle with o_skin, the flag of
// that pixel. results leave in the order the pixels came in.
// throughput: one pixel per cycle, set by the eight-stage datapath: chroma
// offset and cg, rotation multiplies, rotated sums and band compare,
// magnitude rounding, squares, split constant multiplies, term sums and
// the final ellipse compare.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 enable, 1 luma_min, 2 cg_min, 3 cg_max, 4 band_min, 5 band_max);
// other indexes are ignored. write only while no pixel is in flight.
// reset: synchronous, active low; all stage valid bits clear and the
// registers take their reset values. the receiver cannot stall, so the
// pipeline never stops.
module skin_color_pixel_classifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,
    input  logic [7:0]                        i_luma,
    input  logic [7:0]                        i_chroma_red,
    input  logic [7:0]                        i_chroma_blue,
    input  logic                              i_cfg_we,
    input  logic [scpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_valid,
    output logic                              o_skin
);
    import scpc_pkg::*;

    // configuration
    logic       r_enable;
    logic [7:0] r_luma_min;
    logic [7:0] r_cg_min;
    logic [7:0] r_cg_max;
    logic [8:0] r_band_min;
    logic [8:0] r_band_max;

    // stage registers
    logic                     r1_valid, r2_valid, r3_valid, r4_valid;
    logic                     r5_valid, r6_valid, r7_valid;
    logic                     r1_ok, r2_ok, r3_ok, r4_ok, r5_ok, r6_ok, r7_ok;
    logic signed [UV_W-1:0]   r1_u, r1_v;
    logic [CG_W-1:0]          r1_cg;
    logic [7:0]               r1_cr;
    logic signed [P_W-1:0]    r2_cu, r2_sv, r2_su, r2_cv;
    logic [BAND_W-1:0]        r2_band;
    logic signed [X_W-1:0]    r3_x, r3_w;
    logic [R_W-1:0]           r4_xr, r4_wr;
    logic [SQ_W-1:0]          r5_xx, r5_ww;
    logic [PX_W-1:0]          r6_px_lo, r6_px_hi;
    logic [PW_W-1:0]          r6_pw_lo, r6_pw_hi;
    logic [T_W-1:0]           r7_tx, r7_tw;

    // next values
    logic signed [UV_W-1:0]   n_u, n_v;
    logic [CG_W-1:0]          n_cg;
    logic                     n_cg_ok, n_band_ok;
    logic [A_W-1:0]           n_ax, n_aw;
    logic                     n_in_range;
    logic [R_W-1:0]           n_xr, n_wr;
    logic [S_W-1:0]           n_lhs;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= RST_ENABLE;
            r_luma_min <= RST_LUMA_MIN;
            r_cg_min   <= RST_CG_MIN;
            r_cg_max   <= RST_CG_MAX;
            r_band_min <= RST_BAND_MIN;
            r_band_max <= RST_BAND_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_LUMA_MIN: r_luma_min <= i_cfg_data[7:0];
                CFG_CG_MIN:   r_cg_min   <= i_cfg_data[7:0];
                CFG_CG_MAX:   r_cg_max   <= i_cfg_data[7:0];
                CFG_BAND_MIN: r_band_min <= i_cfg_data;
                CFG_BAND_MAX: r_band_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // stage 1: chroma offsets and cg
        n_u  = $signed(UV_W'(i_chroma_blue) * CHROMA_SCALE) - CB_OFFSET;
        n_v  = $signed(UV_W'(i_chroma_red) * CHROMA_SCALE) - CR_OFFSET;
        n_cg = CG_BIAS + CG_W'(i_green) * CG_KG - CG_W'(i_red) * CG_KR
             - CG_W'(i_blue) * CG_KB;
        // stage 2: cg limits
        n_cg_ok = (r1_cg < {r_cg_max, 10'b0}) && (r1_cg > {r_cg_min, 10'b0});
        // stage 3: band limits
        n_band_ok = (r2_band < {r_band_max, 10'b0}) && (r2_band > {r_band_min, 10'b0});
        // stage 4: magnitudes, range and rounding
        n_ax = A_W'(r3_x[X_W-1] ? -r3_x : r3_x);
        n_aw = A_W'(r3_w[X_W-1] ? -r3_w : r3_w);
        n_in_range = (n_ax < AX_LIM) && (n_aw < AW_LIM);
        n_xr = R_W'(({1'b0, n_ax} + ROUND_HALF) >> ROUND_SHIFT);
        n_wr = R_W'(({1'b0, n_aw} + ROUND_HALF) >> ROUND_SHIFT);
        // stage 8: ellipse compare
        n_lhs = S_W'(r7_tx) + S_W'(r7_tw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            o_valid  <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u     <= n_u;
        r1_v     <= n_v;
        r1_cg    <= n_cg;
        r1_cr    <= i_chroma_red;
        r1_ok    <= i_luma > r_luma_min;

        r2_cu    <= P_W'(r1_u) * P_W'(ROT_COS);
        r2_sv    <= P_W'(r1_v) * P_W'(ROT_SIN);
        r2_su    <= P_W'(r1_u) * P_W'(ROT_SIN);
        r2_cv    <= P_W'(r1_v) * P_W'(ROT_COS);
        r2_band  <= {r1_cr, 10'b0} + BAND_W'(r1_cg);
        r2_ok    <= r1_ok && n_cg_ok;

        r3_x     <= X_W'(r2_cu) + X_W'(r2_sv) - X_OFFSET;
        r3_w     <= X_W'(r2_cv) - X_W'(r2_su) - W_OFFSET;
        r3_ok    <= r2_ok && n_band_ok;

        r4_xr    <= n_xr;
        r4_wr    <= n_wr;
        r4_ok    <= r3_ok && n_in_range;

        r5_xx    <= SQ_W'(r4_xr) * SQ_W'(r4_xr);
        r5_ww    <= SQ_W'(r4_wr) * SQ_W'(r4_wr);
        r5_ok    <= r4_ok;

        // constant multiplies split into low and high halves of the squares
        r6_px_lo <= PX_W'(r5_xx[R_W-1:0]) * PX_W'(KX);
        r6_px_hi <= PX_W'(r5_xx[SQ_W-1:R_W]) * PX_W'(KX);
        r6_pw_lo <= PW_W'(r5_ww[R_W-1:0]) * PW_W'(KW);
        r6_pw_hi <= PW_W'(r5_ww[SQ_W-1:R_W]) * PW_W'(KW);
        r6_ok    <= r5_ok;

        r7_tx    <= (T_W'(r6_px_hi) << R_W) + T_W'(r6_px_lo);
        r7_tw    <= (T_W'(r6_pw_hi) << R_W) + T_W'(r6_pw_lo);
        r7_ok    <= r6_ok;

        o_skin   <= !r_enable || (r7_ok && (n_lhs < ELL_LIM));
    end

    // every result traces back to an item that was taken
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without an item");

    // with the test off every pixel is kept
    a_disabled_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(r_enable) |-> o_skin)
        else $error("pixel dropped while disabled");

    // with the test on, a kept pixel passed the luma minimum when it entered
    a_luma_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skin && $past(r_enable)
        |-> $past(i_luma, LATENCY) > $past(r_luma_min, LATENCY))
        else $error("skin flag set below luma minimum");

endmodule
